@@ src/ght_pkg.sv @@
// Package for the generational handle table: field widths, operation and
// status codes, transaction structs, controller states and command/status.
// No dependencies.
package ght_pkg;

   localparam int SLOTS_DEFAULT = 1024;
   localparam int PAYLOAD_W     = 64;
   localparam int HANDLE_W      = 32;
   localparam int VER_W         = 16;
   localparam int IDX_W         = 16;
   localparam int LIVE_W        = 17;

   localparam logic [1:0] KIND_REGISTER   = 2'd0;
   localparam logic [1:0] KIND_LOOKUP     = 2'd1;
   localparam logic [1:0] KIND_UNREGISTER = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;
   localparam logic [1:0] STATUS_BAD  = 2'd3;

   typedef struct packed {
      logic [1:0]           kind;
      logic [PAYLOAD_W-1:0] payload_in;
      logic [HANDLE_W-1:0]  handle_in;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0]  handle_out;
      logic [PAYLOAD_W-1:0] payload_out;
      logic [1:0]           status;
      logic [LIVE_W-1:0]    live_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic exec;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
   } dp_stat_type;

endpackage

@@ src/generational_handle_table.sv @@
// Top level of the generational handle table: controller plus datapath.
// Depends on ght_pkg, ght_ctrl, ght_dp.
//
//  channel   ports                        handshake
//  request   start, busy, req_item        taken when start && !busy
//  response  rsp_valid, rsp_item          one-cycle strobe, no backpressure
//
// In each transaction the accept edge reads the slot metadata and payload
// memories into registers; in the execute state the memories are updated and
// the response register is loaded. busy is high in the execute state; the
// response strobe rsp_valid is registered from the execute state.
// After reset, busy stays high while the metadata memory is swept one entry
// per cycle to rebuild the free list.
// The receiver cannot stall; responses are never held.
module generational_handle_table import ght_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   ght_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   ght_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

@@ src/ght_ctrl.sv @@
// Controller for the generational handle table: clear sweep, idle, execute.
// Depends on ght_pkg.
module ght_ctrl import ght_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   output logic        busy,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      busy       = (state_ff != ST_IDLE);
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.accept = (state_ff == ST_IDLE) && start;
      cmd.exec   = (state_ff == ST_EXEC);
   end

endmodule

@@ src/ght_dp.sv @@
// Datapath for the generational handle table: slot metadata and payload
// memories, free-list head, live count and response register. Depends on ght_pkg.
module ght_dp import ght_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item
);

   localparam int IW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS + 1);
   localparam logic [LW-1:0]    SLOTS_L = LW'(SLOTS);
   localparam logic [IDX_W:0]   SLOTS_H = (IDX_W + 1)'(SLOTS);
   localparam logic [IW-1:0]    LAST_IX = IW'(SLOTS - 1);

   typedef struct packed {
      logic             occ;
      logic [VER_W-1:0] ver;
      logic [LW-1:0]    next;
   } meta_type;

   meta_type             meta_mem [SLOTS];
   logic [PAYLOAD_W-1:0] pay_mem  [SLOTS];

   req_type              req_ff;
   logic [IW-1:0]        addr_ff;
   meta_type             meta_rd_ff;
   logic [PAYLOAD_W-1:0] pay_rd_ff;
   logic [LW-1:0]        free_head_ff, free_head_in;
   logic [LW-1:0]        count_ff, count_in;
   logic [IW-1:0]        clr_idx_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic [IW-1:0]        rd_addr;
   logic [IW-1:0]        wr_addr;
   meta_type             meta_wr;
   logic                 meta_we;
   logic                 pay_we;
   logic [IDX_W-1:0]     h_idx;
   logic [VER_W-1:0]     h_ver;
   logic                 in_range;
   logic                 match;
   logic                 full;
   logic [VER_W-1:0]     ver_inc;
   logic [VER_W-1:0]     new_ver;

   assign rd_addr = (req_item.kind == KIND_REGISTER) ? free_head_ff[IW-1:0]
                                                     : req_item.handle_in[IW-1:0];
   assign wr_addr = cmd.clear ? clr_idx_ff : addr_ff;

   // synchronous read at accept
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff     <= req_item;
         addr_ff    <= rd_addr;
         meta_rd_ff <= meta_mem[rd_addr];
         pay_rd_ff  <= pay_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[wr_addr] <= meta_wr;
      if (pay_we)  pay_mem[addr_ff]  <= req_ff.payload_in;
   end

   assign h_idx    = req_ff.handle_in[IDX_W-1:0];
   assign h_ver    = req_ff.handle_in[HANDLE_W-1:IDX_W];
   assign in_range = {1'b0, h_idx} < SLOTS_H;
   assign match    = in_range && meta_rd_ff.occ && (meta_rd_ff.ver == h_ver);
   assign full     = (free_head_ff == SLOTS_L);
   assign ver_inc  = meta_rd_ff.ver + 1'b1;
   assign new_ver  = (ver_inc == '0) ? VER_W'(1) : ver_inc;

   always_comb begin
      meta_we      = 1'b0;
      pay_we       = 1'b0;
      meta_wr      = meta_rd_ff;
      free_head_in = free_head_ff;
      count_in     = count_ff;
      rsp_in.handle_out  = '0;
      rsp_in.payload_out = '0;
      rsp_in.status      = STATUS_BAD;
      if (cmd.clear) begin
         meta_we = 1'b1;
         meta_wr = '{occ: 1'b0, ver: '0, next: LW'(clr_idx_ff) + 1'b1};
      end else if (cmd.exec) begin
         unique case (req_ff.kind)
            KIND_REGISTER: begin
               if (req_ff.payload_in == '0) begin
                  rsp_in.status = STATUS_ZERO;
               end else if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  meta_we           = 1'b1;
                  pay_we            = 1'b1;
                  meta_wr           = '{occ: 1'b1, ver: new_ver, next: meta_rd_ff.next};
                  free_head_in      = meta_rd_ff.next;
                  count_in          = count_ff + 1'b1;
                  rsp_in.status     = STATUS_OK;
                  rsp_in.handle_out = {new_ver, IDX_W'(addr_ff)};
               end
            end
            KIND_LOOKUP: begin
               if (match) begin
                  rsp_in.status      = STATUS_OK;
                  rsp_in.payload_out = pay_rd_ff;
               end
            end
            KIND_UNREGISTER: begin
               if (match) begin
                  meta_we            = 1'b1;
                  meta_wr            = '{occ: 1'b0, ver: meta_rd_ff.ver, next: free_head_ff};
                  free_head_in       = LW'(addr_ff);
                  count_in           = count_ff - 1'b1;
                  rsp_in.status      = STATUS_OK;
                  rsp_in.payload_out = pay_rd_ff;
               end
            end
            default: begin
            end
         endcase
      end
      rsp_in.live_count = LIVE_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         count_ff     <= '0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.exec;
         if (cmd.clear) clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   assign stat.clr_last = (clr_idx_ff == LAST_IX);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item      = rsp_ff;

endmodule

@@ src/ght_checker.sv @@
// Port-level checks for the generational handle table, bound to the top level.
// Depends on ght_pkg and generational_handle_table.
module ght_checker import ght_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_valid)
      else $error("missing response two cycles after accept");

   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back responses");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != STATUS_OK) |->
         (rsp_item.handle_out == '0) && (rsp_item.payload_out == '0))
      else $error("failing transaction returned nonzero handle or payload");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.live_count <= LIVE_W'(SLOTS))
      else $error("live count exceeds table size");

endmodule

bind generational_handle_table ght_checker #(.SLOTS(SLOTS)) u_ght_checker (.*);
